// ----- sv/uidf_pkg.sv -----
// ----------------------------------------------------------------------------
// uidf_pkg
// Shared constants, codes and types of the owner-uid bitmap packet filter.
// ----------------------------------------------------------------------------
package uidf_pkg;

  localparam int USER_SLOTS_DEF = 4;
  localparam int MAP_WORDS_DEF  = 128;
  localparam int WORD_BITS_DEF  = 64;
  localparam int APP_SPAN_DEF   = 8192;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_ERROR = 2'd3;

  localparam int TAG_W  = 16;
  localparam int REST_W = 17;

  localparam int unsigned UID_PER_USER = 100000;
  localparam int unsigned APP_UID_BASE = 10000;

  // uid / 100000 == ((uid >> 5) * DIV_MAGIC) >> DIV_SHIFT for every 32-bit uid
  localparam int DIV_PRE_SHIFT = 5;
  localparam int DIV_SHIFT     = 39;
  localparam int DIV_MAGIC_W   = 28;
  localparam logic [DIV_MAGIC_W-1:0] DIV_MAGIC = 28'd175921861;

  typedef struct packed {
    logic [1:0]       op;
    logic             tbl;
    logic             other;
    logic             uid_valid;
    logic             in_range;
    logic [TAG_W-1:0] user;
  } cls_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_DIV,
    FS_REM,
    FS_WORD,
    FS_BIT
  } fstate_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_EXEC,
    BS_READ,
    BS_SWEEP,
    BS_RESULT
  } bstate_t;

endpackage

// ----- sv/uidf_front.sv -----
// ----------------------------------------------------------------------------
// uidf_front
// Accepts items and splits the uid into user tag, bitmap word and bit.
// ----------------------------------------------------------------------------
module uidf_front #(
  parameter int MAP_WORDS = uidf_pkg::MAP_WORDS_DEF,
  parameter int WORD_BITS = uidf_pkg::WORD_BITS_DEF,
  parameter int APP_SPAN  = uidf_pkg::APP_SPAN_DEF,
  localparam int WW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
  localparam int BW = $clog2(WORD_BITS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           opcode,
  input  logic [1:0]           family,
  input  logic                 uid_valid,
  input  logic [31:0]          uid,
  input  logic                 q_ready,
  output logic                 q_push,
  output uidf_pkg::cls_t       q_cls,
  output logic [WW-1:0]        q_word,
  output logic [BW-1:0]        q_bit
);

  localparam int SH      = 24;
  localparam int RECIP_W = 22;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2**SH + WORD_BITS - 1) / WORD_BITS);
  localparam int WF_W    = uidf_pkg::REST_W + RECIP_W - SH;
  localparam int N_W     = 32 - uidf_pkg::DIV_PRE_SHIFT;
  localparam int P1_W    = N_W + uidf_pkg::DIV_MAGIC_W;
  localparam int P2_W    = uidf_pkg::REST_W + RECIP_W;
  localparam int RW      = uidf_pkg::REST_W;

  uidf_pkg::fstate_t fstate, fstate_next;

  logic [1:0]                  op_r;
  logic [1:0]                  family_r;
  logic                        uidv_r;
  logic [31:0]                 uid_r;
  logic [uidf_pkg::TAG_W-1:0]  quot;
  logic [RW-1:0]               rest;
  logic [RW-1:0]               app;
  logic                        low;
  logic [WF_W-1:0]             word_full;

  logic                        accept;
  logic [P1_W-1:0]             prod1;
  logic [P2_W-1:0]             prod2;
  logic [RW-1:0]               app_c;
  logic [RW-1:0]               bit_full;

  assign in_stall = rst ||
                    !(fstate == uidf_pkg::FS_IDLE || (fstate == uidf_pkg::FS_BIT && q_ready));
  assign accept   = in_valid && !in_stall;

  assign prod1    = P1_W'(uid_r[31:uidf_pkg::DIV_PRE_SHIFT]) * P1_W'(uidf_pkg::DIV_MAGIC);
  assign app_c    = rest - RW'(uidf_pkg::APP_UID_BASE);
  assign prod2    = P2_W'(app_c) * P2_W'(RECIP);
  assign bit_full = app - RW'(word_full * WORD_BITS);

  assign q_cls.op        = op_r;
  assign q_cls.tbl       = family_r[0];
  assign q_cls.other     = family_r[1];
  assign q_cls.uid_valid = uidv_r;
  assign q_cls.in_range  = !low && (app < RW'(APP_SPAN)) && (word_full < WF_W'(MAP_WORDS));
  assign q_cls.user      = quot;
  assign q_word          = word_full[WW-1:0];
  assign q_bit           = bit_full[BW-1:0];

  always_comb begin
    fstate_next = fstate;
    q_push      = 1'b0;
    case (fstate)
      uidf_pkg::FS_IDLE: begin
        if (accept) fstate_next = uidf_pkg::FS_DIV;
      end
      uidf_pkg::FS_DIV:  fstate_next = uidf_pkg::FS_REM;
      uidf_pkg::FS_REM:  fstate_next = uidf_pkg::FS_WORD;
      uidf_pkg::FS_WORD: fstate_next = uidf_pkg::FS_BIT;
      uidf_pkg::FS_BIT: begin
        if (q_ready) begin
          q_push      = 1'b1;
          fstate_next = accept ? uidf_pkg::FS_DIV : uidf_pkg::FS_IDLE;
        end
      end
      default: fstate_next = uidf_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= uidf_pkg::FS_IDLE;
    end else begin
      fstate <= fstate_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= opcode;
      family_r <= family;
      uidv_r   <= uid_valid;
      uid_r    <= uid;
    end
    if (fstate == uidf_pkg::FS_DIV) begin
      quot <= prod1[uidf_pkg::DIV_SHIFT +: uidf_pkg::TAG_W];
    end
    if (fstate == uidf_pkg::FS_REM) begin
      rest <= RW'(uid_r - 32'(quot * uidf_pkg::UID_PER_USER));
    end
    if (fstate == uidf_pkg::FS_WORD) begin
      low       <= rest < RW'(uidf_pkg::APP_UID_BASE);
      app       <= app_c;
      word_full <= prod2[SH +: WF_W];
    end
  end

endmodule

// ----- sv/uidf_fifo.sv -----
// ----------------------------------------------------------------------------
// uidf_fifo
// Short queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module uidf_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  localparam int D  = uidf_pkg::QUEUE_DEPTH;
  localparam int PW = (D > 1) ? $clog2(D) : 1;
  localparam int CW = $clog2(D + 1);

  logic [W-1:0]  entry [D];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full     = count == CW'(D);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(D - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(D - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= push_data;
  end

endmodule

// ----- sv/uidf_back.sv -----
// ----------------------------------------------------------------------------
// uidf_back
// Executes lookups, adds and clears against slot tags and bitmap memory.
// ----------------------------------------------------------------------------
module uidf_back #(
  parameter int USER_SLOTS = uidf_pkg::USER_SLOTS_DEF,
  parameter int MAP_WORDS  = uidf_pkg::MAP_WORDS_DEF,
  parameter int WORD_BITS  = uidf_pkg::WORD_BITS_DEF,
  localparam int WW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
  localparam int BW = $clog2(WORD_BITS)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_pop,
  input  uidf_pkg::cls_t q_cls,
  input  logic [WW-1:0]  q_word,
  input  logic [BW-1:0]  q_bit,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           pass,
  output logic [1:0]     status
);

  localparam int NK    = 2 * USER_SLOTS;
  localparam int SW    = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;
  localparam int KW    = $clog2(NK);
  localparam int DEPTH = NK * MAP_WORDS;
  localparam int AW    = $clog2(DEPTH);

  uidf_pkg::bstate_t bstate, bstate_next;

  uidf_pkg::cls_t             cmd;
  logic [WW-1:0]              word_r;
  logic [BW-1:0]              bit_r;
  logic [KW-1:0]              k_r;
  logic [WW-1:0]              cnt;
  logic                       res_pass;
  logic [1:0]                 res_status;
  logic [uidf_pkg::TAG_W-1:0] slot_user [NK];
  logic [NK-1:0]              slot_used;
  logic [1:0]                 error_flag;
  logic [WORD_BITS-1:0]       mem [DEPTH];
  logic [WORD_BITS-1:0]       rd_data;

  logic [NK-1:0]              match_all;
  logic [USER_SLOTS-1:0]      hit_vec;
  logic [USER_SLOTS-1:0]      free_vec;
  logic                       hit;
  logic                       free_any;
  logic [SW-1:0]              hit_slot;
  logic [SW-1:0]              free_slot;
  logic [KW-1:0]              hit_k;
  logic [KW-1:0]              free_k;
  logic [KW-1:0]              mem_k;
  logic [WW-1:0]              mem_word;
  logic [AW-1:0]              mem_addr;
  logic [WORD_BITS-1:0]       bit_mask;
  logic                       mem_we;
  logic [WORD_BITS-1:0]       mem_wdata;
  logic                       res_ld;
  logic                       res_pass_next;
  logic [1:0]                 res_status_next;
  logic                       alloc;
  logic                       set_err;
  logic                       clr_tbl;
  logic                       load_out;

  always_comb begin
    for (int k = 0; k < NK; k++) begin
      match_all[k] = slot_used[k] && (slot_user[k] == cmd.user);
    end
    for (int s = 0; s < USER_SLOTS; s++) begin
      hit_vec[s]  = cmd.tbl ? match_all[USER_SLOTS + s] : match_all[s];
      free_vec[s] = cmd.tbl ? !slot_used[USER_SLOTS + s] : !slot_used[s];
    end
    hit       = 1'b0;
    free_any  = 1'b0;
    hit_slot  = '0;
    free_slot = '0;
    for (int s = USER_SLOTS - 1; s >= 0; s--) begin
      if (hit_vec[s]) begin
        hit      = 1'b1;
        hit_slot = SW'(s);
      end
      if (free_vec[s]) begin
        free_any  = 1'b1;
        free_slot = SW'(s);
      end
    end
  end

  assign hit_k    = cmd.tbl ? KW'(USER_SLOTS) + KW'(hit_slot) : KW'(hit_slot);
  assign free_k   = cmd.tbl ? KW'(USER_SLOTS) + KW'(free_slot) : KW'(free_slot);
  assign mem_k    = (bstate == uidf_pkg::BS_EXEC) ? hit_k : k_r;
  assign mem_word = (bstate == uidf_pkg::BS_SWEEP) ? cnt : word_r;
  assign mem_addr = AW'(AW'(mem_k) * AW'(MAP_WORDS) + AW'(mem_word));
  assign bit_mask = WORD_BITS'(1) << bit_r;

  always_comb begin
    bstate_next     = bstate;
    q_pop           = 1'b0;
    mem_we          = 1'b0;
    mem_wdata       = rd_data | bit_mask;
    res_ld          = 1'b0;
    res_pass_next   = 1'b0;
    res_status_next = uidf_pkg::ST_OK;
    alloc           = 1'b0;
    set_err         = 1'b0;
    clr_tbl         = 1'b0;
    load_out        = 1'b0;
    case (bstate)
      uidf_pkg::BS_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          bstate_next = uidf_pkg::BS_EXEC;
        end
      end
      uidf_pkg::BS_EXEC: begin
        res_ld      = 1'b1;
        bstate_next = uidf_pkg::BS_RESULT;
        case (cmd.op)
          uidf_pkg::OP_LOOKUP: begin
            res_pass_next = 1'b1;
            if (!cmd.other) begin
              if (error_flag[cmd.tbl]) begin
                res_pass_next   = 1'b0;
                res_status_next = uidf_pkg::ST_ERROR;
              end else if (cmd.uid_valid) begin
                if (!cmd.in_range) res_status_next = uidf_pkg::ST_RANGE;
                else if (hit) bstate_next = uidf_pkg::BS_READ;
              end
            end
          end
          uidf_pkg::OP_ADD: begin
            if (!cmd.other && cmd.uid_valid) begin
              if (!cmd.in_range) begin
                res_status_next = uidf_pkg::ST_RANGE;
              end else if (hit) begin
                bstate_next = uidf_pkg::BS_READ;
              end else if (free_any) begin
                alloc       = 1'b1;
                bstate_next = uidf_pkg::BS_SWEEP;
              end else begin
                set_err         = 1'b1;
                res_status_next = uidf_pkg::ST_FULL;
              end
            end
          end
          uidf_pkg::OP_CLEAR: begin
            if (!cmd.other) clr_tbl = 1'b1;
          end
          default: ;
        endcase
      end
      uidf_pkg::BS_READ: begin
        bstate_next = uidf_pkg::BS_RESULT;
        if (cmd.op == uidf_pkg::OP_LOOKUP) begin
          res_ld        = 1'b1;
          res_pass_next = !rd_data[bit_r];
        end else begin
          mem_we = 1'b1;
        end
      end
      uidf_pkg::BS_SWEEP: begin
        mem_we    = 1'b1;
        mem_wdata = (cnt == word_r) ? bit_mask : '0;
        if (cnt == WW'(MAP_WORDS - 1)) bstate_next = uidf_pkg::BS_RESULT;
      end
      uidf_pkg::BS_RESULT: begin
        if (!out_valid || !out_stall) begin
          load_out    = 1'b1;
          bstate_next = uidf_pkg::BS_IDLE;
        end
      end
      default: bstate_next = uidf_pkg::BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate     <= uidf_pkg::BS_IDLE;
      slot_used  <= '0;
      error_flag <= '0;
      out_valid  <= 1'b0;
    end else begin
      bstate <= bstate_next;
      if (alloc) slot_used[free_k] <= 1'b1;
      if (set_err) error_flag[cmd.tbl] <= 1'b1;
      if (clr_tbl) begin
        error_flag[cmd.tbl] <= 1'b0;
        for (int s = 0; s < USER_SLOTS; s++) begin
          slot_used[cmd.tbl ? USER_SLOTS + s : s] <= 1'b0;
        end
      end
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd    <= q_cls;
      word_r <= q_word;
      bit_r  <= q_bit;
    end
    if (bstate == uidf_pkg::BS_EXEC) begin
      k_r <= alloc ? free_k : hit_k;
      cnt <= '0;
    end else if (bstate == uidf_pkg::BS_SWEEP) begin
      cnt <= cnt + 1'b1;
    end
    if (alloc) slot_user[free_k] <= cmd.user;
    if (res_ld) begin
      res_pass   <= res_pass_next;
      res_status <= res_status_next;
    end
    if (load_out) begin
      pass   <= res_pass;
      status <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[mem_addr];
    if (mem_we) mem[mem_addr] <= mem_wdata;
  end

`ifndef SYNTHESIS
  a_unique_tag: assert property (@(posedge clk) disable iff (rst)
    bstate == uidf_pkg::BS_EXEC |-> $onehot0(hit_vec))
    else $error("duplicate user tag in one table");

  a_sweep_slot: assert property (@(posedge clk) disable iff (rst)
    bstate == uidf_pkg::BS_SWEEP |-> slot_used[k_r] && slot_user[k_r] == cmd.user)
    else $error("sweep on a slot that is not taken by this user");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(bstate) == uidf_pkg::BS_RESULT)
    else $error("output beat raised outside result state");

  a_error_blocks: assert property (@(posedge clk) disable iff (rst)
    bstate == uidf_pkg::BS_RESULT && res_status == uidf_pkg::ST_ERROR |-> !res_pass)
    else $error("table in error but packet passes");
`endif

endmodule

// ----- sv/uid_bitmap_packet_filter_core.sv -----
// ----------------------------------------------------------------------------
// uid_bitmap_packet_filter_core
// Per-family owner-uid packet filter with slot tags and application bitmaps.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid, in_stall, opcode, family,      | to core
//           | uid_valid, uid                           |
//   out     | out_valid, out_stall, pass, status       | from core
//
// The uid split has four steps (quotient, remainder, word, bit); in_stall is high
// meanwhile and in reset, and a new beat is taken as the last is pushed. The back
// runs exec, read and result for a lookup that finds the owner's slot or an add to
// a known user (one memory read-modify-write), exec, a sweep of the new slot's
// bitmap words one per cycle and result for an add that takes a new slot, and exec
// and result for any other item. Reset needs no clearing pass; a slot's bitmap is
// swept when the slot is taken. A two-entry queue lets the front accept while the
// back works, and the output register holds a result while out_stall is high.
// ----------------------------------------------------------------------------
module uid_bitmap_packet_filter_core #(
  parameter int USER_SLOTS = uidf_pkg::USER_SLOTS_DEF,
  parameter int MAP_WORDS  = uidf_pkg::MAP_WORDS_DEF,
  parameter int WORD_BITS  = uidf_pkg::WORD_BITS_DEF,
  parameter int APP_SPAN   = uidf_pkg::APP_SPAN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [1:0]  family,
  input  logic        uid_valid,
  input  logic [31:0] uid,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        pass,
  output logic [1:0]  status
);

  localparam int WW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW = $clog2(WORD_BITS);
  localparam int CW = $bits(uidf_pkg::cls_t);
  localparam int QW = CW + WW + BW;

  uidf_pkg::cls_t f_cls;
  uidf_pkg::cls_t b_cls;
  logic [WW-1:0]  f_word;
  logic [BW-1:0]  f_bit;
  logic [WW-1:0]  b_word;
  logic [BW-1:0]  b_bit;
  logic           f_push;
  logic           q_full;
  logic           q_empty;
  logic           b_pop;
  logic [QW-1:0]  q_in;
  logic [QW-1:0]  q_out;

  assign q_in                  = {f_cls, f_word, f_bit};
  assign b_cls                 = q_out[QW-1 -: CW];
  assign b_word                = q_out[BW +: WW];
  assign b_bit                 = q_out[BW-1:0];

  uidf_front #(
    .MAP_WORDS (MAP_WORDS),
    .WORD_BITS (WORD_BITS),
    .APP_SPAN  (APP_SPAN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .family    (family),
    .uid_valid (uid_valid),
    .uid       (uid),
    .q_ready   (!q_full),
    .q_push    (f_push),
    .q_cls     (f_cls),
    .q_word    (f_word),
    .q_bit     (f_bit)
  );

  uidf_fifo #(
    .W (QW)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (b_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  uidf_back #(
    .USER_SLOTS (USER_SLOTS),
    .MAP_WORDS  (MAP_WORDS),
    .WORD_BITS  (WORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (!q_empty),
    .q_pop     (b_pop),
    .q_cls     (b_cls),
    .q_word    (b_word),
    .q_bit     (b_bit),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pass      (pass),
    .status    (status)
  );

endmodule

// ----- tb/sv/tb_uid_bitmap_packet_filter_core.sv -----
// ----------------------------------------------------------------------------
// tb_uid_bitmap_packet_filter_core
// Self-checking bench for the owner-uid bitmap packet filter.
//
// A directed run covers the table edges: unknown owners, uids outside the
// application range, a full table and its error flag, other families, the
// unused opcode and clears. Four random phases with different idle and stall
// rates follow. A scoreboard model keeps its own copy of the slot tags,
// bitmaps and error flags, predicts each result and checks every beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_uid_bitmap_packet_filter_core;

  localparam int NSLOT  = uidf_pkg::USER_SLOTS_DEF;
  localparam int NWORD  = uidf_pkg::MAP_WORDS_DEF;
  localparam int WBITS  = uidf_pkg::WORD_BITS_DEF;
  localparam int NAPP   = uidf_pkg::APP_SPAN_DEF;
  localparam int unsigned PER_USER = uidf_pkg::UID_PER_USER;
  localparam int unsigned APP_BASE = uidf_pkg::APP_UID_BASE;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 3 + NWORD + 60;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] FAM_V4    = 2'd0;
  localparam logic [1:0] FAM_V6    = 2'd1;
  localparam logic [1:0] FAM_OTHER = 2'd2;
  localparam logic [1:0] FAM_RSVD  = 2'd3;

  typedef struct {
    logic [1:0]  opcode;
    logic [1:0]  family;
    logic        uid_valid;
    logic [31:0] uid;
  } filter_cmd_t;

  typedef struct {
    logic       pass;
    logic [1:0] status;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = '0;
  logic [1:0]  family = '0;
  logic        uid_valid = 1'b0;
  logic [31:0] uid = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        pass;
  logic [1:0]  status;

  filter_cmd_t cmd_fifo[$];
  verdict_t    verdict_fifo[$];
  filter_cmd_t cur_cmd;
  bit          beat_taken = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cmds_queued = 0;
  int beats_in = 0;
  int results_seen = 0;
  int n_lookup = 0, n_add = 0, n_clear = 0;
  int n_blocked = 0, n_range = 0, n_full = 0, n_in_error = 0;
  int fail_count = 0;
  int cycle_count = 0;

  // scoreboard copy of the filter state
  logic [15:0]      tag_user [2*NSLOT];
  bit               tag_used [2*NSLOT];
  logic [WBITS-1:0] app_bits [2*NSLOT*NWORD];
  bit               tbl_error[2];

  uid_bitmap_packet_filter_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .family(family), .uid_valid(uid_valid), .uid(uid),
    .out_valid(out_valid), .out_stall(out_stall),
    .pass(pass), .status(status)
  );

  always #5 clk = ~clk;

  function automatic void wipe_table(input int t);
    int s, w;
    for (s = 0; s < NSLOT; s++) begin
      tag_user[t*NSLOT+s] = '0;
      tag_used[t*NSLOT+s] = 1'b0;
      for (w = 0; w < NWORD; w++) app_bits[(t*NSLOT+s)*NWORD+w] = '0;
    end
    tbl_error[t] = 1'b0;
  endfunction

  function automatic verdict_t filter_predict(input filter_cmd_t c);
    verdict_t v;
    int unsigned u, rest, app, user, wi, bi;
    int s, k, w, t;
    bit in_range, done;
    v.pass = 1'b0;
    v.status = uidf_pkg::ST_OK;
    t = c.family[0];
    u = c.uid;
    rest = u % PER_USER;
    user = (u / PER_USER) & 32'hFFFF;
    in_range = (rest >= APP_BASE) && (rest - APP_BASE < NAPP);
    app = in_range ? rest - APP_BASE : 0;
    wi = app / WBITS;
    bi = app % WBITS;
    in_range = in_range && (wi < NWORD);
    case (c.opcode)
      uidf_pkg::OP_LOOKUP: begin
        v.pass = 1'b1;
        if (c.family <= FAM_V6) begin
          if (tbl_error[t]) begin
            v.pass = 1'b0;
            v.status = uidf_pkg::ST_ERROR;
          end else if (c.uid_valid) begin
            if (!in_range) v.status = uidf_pkg::ST_RANGE;
            else begin
              for (s = 0; s < NSLOT; s++) begin
                k = t*NSLOT + s;
                if (tag_used[k] && tag_user[k] == user[15:0] && app_bits[k*NWORD+wi][bi])
                  v.pass = 1'b0;
              end
            end
          end
        end
      end
      uidf_pkg::OP_ADD: begin
        if (c.family <= FAM_V6 && c.uid_valid) begin
          if (!in_range) v.status = uidf_pkg::ST_RANGE;
          else begin
            done = 1'b0;
            for (s = 0; s < NSLOT && !done; s++) begin
              k = t*NSLOT + s;
              if (tag_used[k] && tag_user[k] == user[15:0]) begin
                app_bits[k*NWORD+wi][bi] = 1'b1;
                done = 1'b1;
              end
            end
            for (s = 0; s < NSLOT && !done; s++) begin
              k = t*NSLOT + s;
              if (!tag_used[k]) begin
                tag_used[k] = 1'b1;
                tag_user[k] = user[15:0];
                for (w = 0; w < NWORD; w++) app_bits[k*NWORD+w] = '0;
                app_bits[k*NWORD+wi][bi] = 1'b1;
                done = 1'b1;
              end
            end
            if (!done) begin
              tbl_error[t] = 1'b1;
              v.status = uidf_pkg::ST_FULL;
            end
          end
        end
      end
      uidf_pkg::OP_CLEAR: if (c.family <= FAM_V6) wipe_table(t);
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] make_uid(input int unsigned user, input int unsigned app);
    return user * PER_USER + APP_BASE + app;
  endfunction

  task automatic push_cmd(input logic [1:0] op, input logic [1:0] fam, input logic valid,
                          input logic [31:0] id);
    filter_cmd_t c;
    c.opcode = op;
    c.family = fam;
    c.uid_valid = valid;
    c.uid = id;
    cmd_fifo.push_back(c);
    cmds_queued++;
  endtask

  task automatic push_random_cmd();
    int unsigned user_pool[6] = '{0, 1, 2, 1000, 30000, 42949};
    int unsigned hot_apps[8] = '{0, 1, 63, 64, 127, 4095, 8000, 8191};
    int unsigned user, app, r;
    logic [1:0] op, fam;
    logic [31:0] id;
    r = $urandom_range(99);
    if (r < 8) begin
      push_cmd(2'($urandom_range(3)), 2'($urandom_range(3)), 1'($urandom_range(1)),
               $urandom);
    end else if (r < 12) begin
      push_cmd(uidf_pkg::OP_CLEAR, ($urandom_range(9) == 0) ? 2'($urandom_range(3)) :
               2'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
    end else begin
      op = (r < 50) ? uidf_pkg::OP_ADD : uidf_pkg::OP_LOOKUP;
      fam = ($urandom_range(19) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(1));
      user = ($urandom_range(9) == 0) ? user_pool[4 + $urandom_range(1)] :
             user_pool[$urandom_range(3)];
      app = $urandom_range(1) ? hot_apps[$urandom_range(7)] : $urandom_range(NAPP - 1);
      id = make_uid(user, app);
      if ($urandom_range(19) == 0)
        id = $urandom_range(1) ? user * PER_USER + $urandom_range(APP_BASE - 1) :
             make_uid(user, NAPP + $urandom_range(PER_USER - APP_BASE - NAPP - 1));
      push_cmd(op, fam, $urandom_range(19) != 0, id);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (beats_in != cmds_queued || verdict_fifo.size() != 0);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) push_random_cmd();
    wait_idle();
  endtask

  // driver: predict on each accepted beat, present the next command at the falling edge
  always @(posedge clk) begin
    beat_taken = !rst && in_valid && !in_stall;
    if (beat_taken) begin
      verdict_fifo.push_back(filter_predict(cur_cmd));
      beats_in++;
      case (cur_cmd.opcode)
        uidf_pkg::OP_LOOKUP: n_lookup++;
        uidf_pkg::OP_ADD:    n_add++;
        uidf_pkg::OP_CLEAR:  n_clear++;
        default: ;
      endcase
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || beat_taken) begin
      if (cmd_fifo.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_cmd = cmd_fifo.pop_front();
        in_valid <= 1'b1;
        opcode <= cur_cmd.opcode;
        family <= cur_cmd.family;
        uid_valid <= cur_cmd.uid_valid;
        uid <= cur_cmd.uid;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin : result_check
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (!pass && status == uidf_pkg::ST_OK) n_blocked++;
      if (status == uidf_pkg::ST_RANGE) n_range++;
      if (status == uidf_pkg::ST_FULL) n_full++;
      if (status == uidf_pkg::ST_ERROR) n_in_error++;
      if (verdict_fifo.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result beat, pass=%0b status=%0d", $time, pass, status);
      end else begin
        want = verdict_fifo.pop_front();
        if (pass !== want.pass) begin
          fail_count++;
          $display("%0t: pass mismatch, expected %0b, got %0b", $time, want.pass, pass);
        end
        if (status !== want.status) begin
          fail_count++;
          $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, status);
        end
      end
    end
  end

  always @(negedge clk) out_stall <= !rst && ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    wipe_table(0);
    wipe_table(1);
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    push_cmd(uidf_pkg::OP_LOOKUP, FAM_V4, 1'b1, make_uid(0, 0));
    push_cmd(uidf_pkg::OP_ADD,    FAM_V4, 1'b1, make_uid(0, 0));
    push_cmd(uidf_pkg::OP_LOOKUP, FAM_V4, 1'b1, make_uid(0, 0));
    push_cmd(uidf_pkg::OP_LOOKUP, FAM_V6, 1'b1, make_uid(0, 0));
    push_cmd(uidf_pkg::OP_ADD,    FAM_V4, 1'b1, make_uid(42949, NAPP - 1));
    push_cmd(uidf_pkg::OP_LOOKUP, FAM_V4, 1'b1, make_uid(42949, NAPP - 1));
    push_cmd(uidf_pkg::OP_ADD,    FAM_V4, 1'b1, APP_BASE - 1);
    push_cmd(uidf_pkg::OP_ADD,    FAM_V4, 1'b1, make_uid(0, NAPP));
    push_cmd(uidf_pkg::OP_LOOKUP, FAM_V4, 1'b1, 32'hFFFF_FFFF);
    push_cmd(uidf_pkg::OP_LOOKUP, FAM_V4, 1'b0, make_uid(0, 0));
    push_cmd(uidf_pkg::OP_ADD,    FAM_V4, 1'b0, make_uid(5, 5));
    push_cmd(uidf_pkg::OP_ADD,    FAM_V4, 1'b1, make_uid(7, 63));
    push_cmd(uidf_pkg::OP_ADD,    FAM_V4, 1'b1, make_uid(8, 64));
    push_cmd(uidf_pkg::OP_ADD,    FAM_V4, 1'b1, make_uid(9, 5));
    push_cmd(uidf_pkg::OP_LOOKUP, FAM_V4, 1'b1, make_uid(42949, NAPP - 1));
    push_cmd(uidf_pkg::OP_ADD,    FAM_V4, 1'b1, make_uid(0, 1));
    push_cmd(uidf_pkg::OP_LOOKUP, FAM_OTHER, 1'b1, make_uid(0, 0));
    push_cmd(uidf_pkg::OP_ADD,    FAM_OTHER, 1'b1, make_uid(3, 3));
    push_cmd(uidf_pkg::OP_CLEAR,  FAM_RSVD, 1'b1, 32'hFFFF_FFFF);
    push_cmd(OP_UNUSED,           FAM_V4, 1'b1, make_uid(0, 0));
    push_cmd(uidf_pkg::OP_CLEAR,  FAM_V4, 1'b0, '0);
    push_cmd(uidf_pkg::OP_LOOKUP, FAM_V4, 1'b1, make_uid(0, 0));
    push_cmd(uidf_pkg::OP_LOOKUP, FAM_RSVD, 1'b0, '0);
    push_cmd(uidf_pkg::OP_ADD,    FAM_V6, 1'b1, '0);
    push_cmd(uidf_pkg::OP_CLEAR,  FAM_V6, 1'b1, '0);
    // hold the sender until the directed results are all back
    wait_idle();

    run_phase(0, 0, 105);
    run_phase(85, 0, 100);
    run_phase(0, 85, 100);
    run_phase(17, 17, 120);

    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Sent %0d beats (%0d lookups, %0d adds, %0d clears), checked %0d results",
             beats_in, n_lookup, n_add, n_clear, results_seen);
    $display("Seen: %0d blocked, %0d out of range, %0d table full, %0d table in error",
             n_blocked, n_range, n_full, n_in_error);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
